// ===== sv/lbt_pkg.sv =====
// Types and constants for the block buffer tag engine.
// No dependencies; used by the top level, lbt_ctrl, lbt_dpath and lbt_checker.
package lbt_pkg;

    localparam int AGE_W = 32;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_INVAL  = 1'b1;

    typedef logic [7:0]  t_table_id;
    typedef logic [19:0] t_offset;
    typedef logic [3:0]  t_slot;
    typedef logic [4:0]  t_count;

    typedef struct packed {
        logic      op;
        t_table_id table_id;
        logic      file_kind;
        t_offset   block_offset;
    } t_req;

    typedef struct packed {
        logic      hit;
        t_slot     slot;
        logic      evicted;
        t_table_id victim_table;
        logic      victim_type;
        t_offset   victim_offset;
        t_count    freed_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_SELECT,
        S_SCAN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic match;
        logic select;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_evict;
        logic scan_last;
    } t_status;

endpackage

// ===== sv/lbt_stream_if.sv =====
// Valid/ready stream interface carrying one payload word.
// Payload type is a parameter; depends on nothing else.
interface lbt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/lru_block_buffer_tags.sv =====
// Top level of the block buffer tag engine: sequencer plus datapath.
// Depends on lbt_pkg, lbt_stream_if, lbt_ctrl and lbt_dpath.
//
//   port    dir   word          meaning
//   i_req   in    lbt_pkg::t_req  access or table-file invalidate
//   o_rsp   out   lbt_pkg::t_rsp  hit/slot/victim or freed count
//
// A word passes through capture, match, select and commit; a miss with no
// free slot adds an age scan over all SLOTS slots before commit, one slot
// per cycle through the age read mux.
// Synchronous reset clears valid bits and ages; tags are left as they are.
// The result register holds one word; the next request is accepted and
// worked on while it waits, and its commit stalls until the register drains.
module lru_block_buffer_tags #(
    parameter int SLOTS       = 16,
    parameter int OFFSET_BITS = 20,
    parameter int TABLE_BITS  = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lbt_stream_if.sink    i_req,
    lbt_stream_if.source  o_rsp
);

    lbt_pkg::t_cmd    cmd;
    lbt_pkg::t_status status;
    logic             in_ready;
    logic             out_valid;

    lbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lbt_dpath #(
        .SLOTS       (SLOTS),
        .OFFSET_BITS (OFFSET_BITS),
        .TABLE_BITS  (TABLE_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_req_data (i_req.data),
        .o_rsp_data (o_rsp.data)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule

// ===== sv/lbt_ctrl.sv =====
// Sequencer for the tag engine: handshakes, step commands, result valid.
// Depends on lbt_pkg.
module lbt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lbt_pkg::t_status  i_status,
    output lbt_pkg::t_cmd     o_cmd
);

    lbt_pkg::t_state r_state;
    lbt_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lbt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = lbt_pkg::S_MATCH;
                end
            end
            lbt_pkg::S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = lbt_pkg::S_SELECT;
            end
            lbt_pkg::S_SELECT: begin
                o_cmd.select = 1'b1;
                n_state      = i_status.need_evict ? lbt_pkg::S_SCAN : lbt_pkg::S_COMMIT;
            end
            lbt_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = lbt_pkg::S_COMMIT;
                end
            end
            lbt_pkg::S_COMMIT: begin
                // result register must be empty or draining this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = lbt_pkg::S_IDLE;
                end
            end
            default: n_state = lbt_pkg::S_IDLE;
        endcase
        n_out_valid = o_cmd.commit | (r_out_valid & ~i_out_ready);
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/lbt_dpath.sv =====
// Slot tags, valid bits, ages, match/priority logic, age scan, result register.
// Depends on lbt_pkg; driven by lbt_ctrl commands.
module lbt_dpath #(
    parameter int SLOTS       = 16,
    parameter int OFFSET_BITS = 20,
    parameter int TABLE_BITS  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbt_pkg::t_cmd     i_cmd,
    output lbt_pkg::t_status  o_status,
    input  lbt_pkg::t_req     i_req_data,
    output lbt_pkg::t_rsp     o_rsp_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int KEY_W = TABLE_BITS + 1;
    localparam int TAG_W = KEY_W + OFFSET_BITS;
    localparam int AGE_W = lbt_pkg::AGE_W;

    // tag layout: {table, type, offset}
    logic [SLOTS-1:0] r_valid;
    logic [TAG_W-1:0] r_tag [SLOTS];
    logic [AGE_W-1:0] r_age [SLOTS];

    logic             r_op;
    logic [TAG_W-1:0] r_key_tag;
    logic [SLOTS-1:0] r_match;
    logic [SLOTS-1:0] r_free;
    logic             r_hit;
    logic             r_evict;
    logic [IDX_W-1:0] r_target;
    logic [IDX_W-1:0] r_scan_idx;
    logic [AGE_W-1:0] r_best_age;
    lbt_pkg::t_rsp    r_rsp;

    logic [SLOTS-1:0] n_match;
    lbt_pkg::t_rsp    n_rsp;
    logic             hit_any;
    logic             free_any;
    logic             need_evict;
    logic [IDX_W-1:0] first_hit;
    logic [IDX_W-1:0] first_free;
    logic [AGE_W-1:0] scan_age;
    logic [TAG_W-1:0] victim_tag;

    // invalidate compares only table and type
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (r_op == lbt_pkg::OP_INVAL) begin
                n_match[i] = r_valid[i] &&
                    (r_tag[i][TAG_W-1:OFFSET_BITS] == r_key_tag[TAG_W-1:OFFSET_BITS]);
            end else begin
                n_match[i] = r_valid[i] && (r_tag[i] == r_key_tag);
            end
        end
    end

    always_comb begin
        first_hit  = '0;
        first_free = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) first_hit = IDX_W'(i);
            if (r_free[i])  first_free = IDX_W'(i);
        end
    end

    assign hit_any    = |r_match;
    assign free_any   = |r_free;
    assign need_evict = (r_op == lbt_pkg::OP_ACCESS) && !hit_any && !free_any;
    assign scan_age   = r_age[r_scan_idx];
    assign victim_tag = r_tag[r_target];

    assign o_status.need_evict = need_evict;
    assign o_status.scan_last  = (r_scan_idx == IDX_W'(SLOTS - 1));

    always_comb begin
        n_rsp = '0;
        if (r_op == lbt_pkg::OP_INVAL) begin
            n_rsp.freed_count = lbt_pkg::t_count'($countones(r_match));
        end else begin
            n_rsp.hit     = r_hit;
            n_rsp.slot    = lbt_pkg::t_slot'(r_target);
            n_rsp.evicted = r_evict;
            if (r_evict) begin
                n_rsp.victim_table  = lbt_pkg::t_table_id'(victim_tag[TAG_W-1 -: TABLE_BITS]);
                n_rsp.victim_type   = victim_tag[OFFSET_BITS];
                n_rsp.victim_offset = lbt_pkg::t_offset'(victim_tag[OFFSET_BITS-1:0]);
            end
        end
    end

    // valid bits and ages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_age[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (r_op == lbt_pkg::OP_INVAL) begin
                    if (r_match[i]) begin
                        r_valid[i] <= 1'b0;
                        r_age[i]   <= '0;
                    end
                end else if (IDX_W'(i) == r_target) begin
                    r_valid[i] <= 1'b1;
                    r_age[i]   <= '0;
                end else if (r_valid[i] && (r_age[i] != '1)) begin
                    r_age[i] <= r_age[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_op == lbt_pkg::OP_ACCESS)) begin
            r_tag[r_target] <= r_key_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_req_data.op;
            r_key_tag <= {TABLE_BITS'(i_req_data.table_id), i_req_data.file_kind,
                          OFFSET_BITS'(i_req_data.block_offset)};
        end
        if (i_cmd.match) begin
            r_match <= n_match;
            r_free  <= ~r_valid;
        end
        if (i_cmd.select) begin
            r_hit      <= hit_any;
            r_evict    <= need_evict;
            r_scan_idx <= '0;
            if (need_evict) begin
                r_target   <= '0;
                r_best_age <= '0;
            end else if (hit_any) begin
                r_target <= first_hit;
            end else begin
                r_target <= first_free;
            end
        end
        // oldest slot, lowest index wins a tie
        if (i_cmd.scan) begin
            r_scan_idx <= r_scan_idx + 1'b1;
            if (scan_age > r_best_age) begin
                r_best_age <= scan_age;
                r_target   <= r_scan_idx;
            end
        end
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_data = r_rsp;

endmodule

// ===== sv/lbt_checker.sv =====
// Port-level checks for lru_block_buffer_tags, attached by bind.
// Depends on lbt_pkg and the top level's ports.
module lbt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          o_rsp_valid,
    input logic          o_rsp_ready,
    input lbt_pkg::t_rsp o_rsp_data
);

    // words accepted but not yet delivered
    logic [1:0] r_pending;
    logic [1:0] n_pending;

    always_comb begin
        n_pending = r_pending;
        if ((i_req_valid && i_req_ready) && !(o_rsp_valid && o_rsp_ready)) begin
            n_pending = r_pending + 2'd1;
        end else if (!(i_req_valid && i_req_ready) && (o_rsp_valid && o_rsp_ready)) begin
            n_pending = r_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp_valid)
        else $error("result valid right after reset");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (r_pending != 2'd0) && (r_pending != 2'd3))
        else $error("result count does not match accepted requests");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp_data.hit) |->
            !o_rsp_data.evicted && (o_rsp_data.freed_count == '0))
        else $error("hit word also reports eviction or freed slots");

    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp_data.evicted) |->
            (o_rsp_data.victim_table == '0) && !o_rsp_data.victim_type &&
            (o_rsp_data.victim_offset == '0))
        else $error("victim fields set without eviction");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp_ready) |=> o_rsp_valid && $stable(o_rsp_data))
        else $error("stalled result word changed");

endmodule

bind lru_block_buffer_tags lbt_checker u_lbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .o_rsp_valid (o_rsp.valid),
    .o_rsp_ready (o_rsp.ready),
    .o_rsp_data  (o_rsp.data)
);
